FILE: design/gasp_pkg.sv
// Shared types, codes and helper functions of the grid path search unit.
package gasp_pkg;

   localparam int ROW_W   = 5;
   localparam int COL_W   = 5;
   localparam int CELL_W  = ROW_W + COL_W;
   localparam int DIM_W   = 6;
   localparam int COST_W  = 11;
   localparam int CNT_W   = 11;
   localparam int F_W     = 11;
   localparam int H_W     = 6;
   localparam int DIR_W   = 3;
   localparam int CELLS   = 1 << CELL_W;
   localparam int OPEN_W  = CELL_W + F_W;
   localparam int PATH_W  = CELL_W + DIR_W;

   localparam logic [DIM_W-1:0]  DIM_MAX  = 6'd32;
   localparam logic [COST_W-1:0] COST_INF = 11'h7FF;

   localparam logic [1:0] KIND_OPEN = 2'd0;
   localparam logic [1:0] KIND_OBST = 2'd1;
   localparam logic [1:0] KIND_GOAL = 2'd2;
   localparam logic [1:0] KIND_RSVD = 2'd3;

   localparam logic [DIR_W-1:0] DIR_UP    = 3'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_NONE  = 3'd4;

   localparam logic [2:0] REG_ROWS      = 3'd0;
   localparam logic [2:0] REG_COLS      = 3'd1;
   localparam logic [2:0] REG_MODE      = 3'd2;
   localparam logic [2:0] REG_START_ROW = 3'd3;
   localparam logic [2:0] REG_START_COL = 3'd4;
   localparam logic [2:0] REG_GOAL_ROW  = 3'd5;
   localparam logic [2:0] REG_GOAL_COL  = 3'd6;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_STEP   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_LOADED = 2'd0,
      ST_FOUND  = 2'd1,
      ST_NOPATH = 2'd2,
      ST_BEYOND = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_STEP_RSP,
      S_CLEAR,
      S_START,
      S_POP,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_CHK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_POP_DONE,
      S_CLOSE,
      S_NB_ISSUE,
      S_NB_EVAL,
      S_TRACE_INIT,
      S_TRACE_CHK,
      S_TRACE_RD,
      S_TRACE_PAR,
      S_TRACE_END,
      S_FAIL
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_STEP_RD,
      OP_STEP_RSP,
      OP_INIT,
      OP_CLEAR,
      OP_START,
      OP_SCAN_INIT,
      OP_SCAN_RD,
      OP_SCAN_CMP,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_POP_DONE,
      OP_CLOSE,
      OP_NB_ISSUE,
      OP_NB_EVAL,
      OP_TRACE_INIT,
      OP_TRACE_RD,
      OP_TRACE_PAR,
      OP_TRACE_END,
      OP_FAIL
   } op_type;

   typedef struct packed {
      logic count_zero;
      logic clear_done;
      logic start_oob;
      logic scan_last;
      logic shift_more;
      logic is_goal;
      logic nb_in;
      logic dir_last;
      logic at_start;
      logic trace_full;
      logic par_ok;
   } dp_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = 6'd1;
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   function automatic logic [H_W-1:0] manhattan(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c,
                                               input logic [ROW_W-1:0] gr,
                                               input logic [COL_W-1:0] gc);
      logic [ROW_W-1:0] dr;
      logic [COL_W-1:0] dc;
      dr = (r >= gr) ? (r - gr) : (gr - r);
      dc = (c >= gc) ? (c - gc) : (gc - c);
      return {1'b0, dr} + {1'b0, dc};
   endfunction

endpackage

FILE: design/grid_astar_path_search_unit.sv
// A cell load is answered in the next cycle; a step read passes the path memory read
// register, then the response register. A search sweeps the 1024-entry cost memory,
// then each pop scans every open-list entry, shifts those after the best one down,
// closes the cell and visits its neighbours; trace-back walks the parent links. Loads
// go one per cycle unless the response is held; a step read or search stalls the input
// until its result is formed. Reset is synchronous and active high: no path is held.
module grid_astar_path_search_unit import gasp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [ROW_W-1:0]   req_cell_row,
   input  logic [COL_W-1:0]   req_cell_col,
   input  logic [1:0]         req_cell_kind,
   input  logic [9:0]         req_step_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [CNT_W-1:0]   rsp_path_length,
   output logic [ROW_W-1:0]   rsp_step_row,
   output logic [COL_W-1:0]   rsp_step_col,
   output logic [DIR_W-1:0]   rsp_step_dir,
   output logic               rsp_last_step,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [DIM_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic             mode_ff, mode_in;
   logic [ROW_W-1:0] start_row_ff, start_row_in, goal_row_ff, goal_row_in;
   logic [COL_W-1:0] start_col_ff, start_col_in, goal_col_ff, goal_col_in;
   logic             csr_write;
   logic [2:0]       csr_index;
   op_type           op;
   dp_status_type    status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[4:2];

   always_comb begin
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      mode_in      = mode_ff;
      start_row_in = start_row_ff;
      start_col_in = start_col_ff;
      goal_row_in  = goal_row_ff;
      goal_col_in  = goal_col_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_ROWS:      rows_in      = pwdata[DIM_W-1:0];
            REG_COLS:      cols_in      = pwdata[DIM_W-1:0];
            REG_MODE:      mode_in      = pwdata[0];
            REG_START_ROW: start_row_in = pwdata[ROW_W-1:0];
            REG_START_COL: start_col_in = pwdata[COL_W-1:0];
            REG_GOAL_ROW:  goal_row_in  = pwdata[ROW_W-1:0];
            REG_GOAL_COL:  goal_col_in  = pwdata[COL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ROWS:      prdata = {26'd0, rows_ff};
         REG_COLS:      prdata = {26'd0, cols_ff};
         REG_MODE:      prdata = {31'd0, mode_ff};
         REG_START_ROW: prdata = {27'd0, start_row_ff};
         REG_START_COL: prdata = {27'd0, start_col_ff};
         REG_GOAL_ROW:  prdata = {27'd0, goal_row_ff};
         REG_GOAL_COL:  prdata = {27'd0, goal_col_ff};
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= DIM_MAX;
         cols_ff      <= DIM_MAX;
         mode_ff      <= 1'b1;
         start_row_ff <= '0;
         start_col_ff <= '0;
         goal_row_ff  <= '0;
         goal_col_ff  <= '0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         mode_ff      <= mode_in;
         start_row_ff <= start_row_in;
         start_col_ff <= start_col_in;
         goal_row_ff  <= goal_row_in;
         goal_col_ff  <= goal_col_in;
      end
   end

   gasp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .rsp_hold   (rsp_valid && rsp_stall),
      .status     (status),
      .op         (op),
      .req_stall  (req_stall)
   );

   gasp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .op              (op),
      .status          (status),
      .req_cell_row    (req_cell_row),
      .req_cell_col    (req_cell_col),
      .req_cell_kind   (req_cell_kind),
      .req_step_index  (req_step_index),
      .cfg_rows        (rows_ff),
      .cfg_cols        (cols_ff),
      .cfg_mode        (mode_ff),
      .cfg_start_row   (start_row_ff),
      .cfg_start_col   (start_col_ff),
      .cfg_goal_row    (goal_row_ff),
      .cfg_goal_col    (goal_col_ff),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_path_length (rsp_path_length),
      .rsp_step_row    (rsp_step_row),
      .rsp_step_col    (rsp_step_col),
      .rsp_step_dir    (rsp_step_dir),
      .rsp_last_step   (rsp_last_step)
   );

`ifndef SYNTH
   // A search transfer holds the input off in the following cycle.
   a_search_stalls: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_SEARCH) |=> req_stall)
      else $error("search transfer did not stall the input");

   // A cell load is answered in the next cycle with the loaded status.
   a_load_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_action == ACT_LOAD)
      |=> rsp_valid && (rsp_status == ST_LOADED))
      else $error("cell load not answered");

   // A found path always holds at least the start cell.
   a_found_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FOUND) |-> (rsp_path_length != '0))
      else $error("found path with zero length");
`endif

endmodule

FILE: design/gasp_ctrl.sv
// Sequencer of the path search unit: decides one datapath operation per cycle.
module gasp_ctrl import gasp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_action,
   input  logic          rsp_hold,
   input  dp_status_type status,
   output op_type        op,
   output logic          req_stall
);

   state_type state_ff, state_in;
   logic      accept;

   assign accept = (state_ff == S_IDLE) && req_valid && !rsp_hold;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (action_type'(req_action))
                  ACT_SEARCH: state_in = S_CLEAR;
                  ACT_STEP:   state_in = S_STEP_RSP;
                  ACT_LOAD:   state_in = S_IDLE;
                  ACT_NONE:   state_in = S_IDLE;
               endcase
            end
         end
         S_STEP_RSP:  state_in = S_IDLE;
         S_CLEAR: begin
            if (status.clear_done) begin
               state_in = status.start_oob ? S_FAIL : S_START;
            end
         end
         S_START:     state_in = S_POP;
         S_POP:       state_in = status.count_zero ? S_FAIL : S_SCAN_RD;
         S_SCAN_RD:   state_in = S_SCAN_CMP;
         S_SCAN_CMP:  state_in = status.scan_last ? S_SHIFT_CHK : S_SCAN_RD;
         S_SHIFT_CHK: state_in = status.shift_more ? S_SHIFT_RD : S_POP_DONE;
         S_SHIFT_RD:  state_in = S_SHIFT_WR;
         S_SHIFT_WR:  state_in = S_SHIFT_CHK;
         S_POP_DONE:  state_in = S_CLOSE;
         S_CLOSE:     state_in = status.is_goal ? S_TRACE_INIT : S_NB_ISSUE;
         S_NB_ISSUE: begin
            if (status.nb_in) begin
               state_in = S_NB_EVAL;
            end else begin
               state_in = status.dir_last ? S_POP : S_NB_ISSUE;
            end
         end
         S_NB_EVAL:   state_in = status.dir_last ? S_POP : S_NB_ISSUE;
         S_TRACE_INIT: state_in = S_TRACE_CHK;
         S_TRACE_CHK: begin
            priority if (status.at_start) begin
               state_in = S_TRACE_END;
            end else if (status.trace_full) begin
               state_in = S_FAIL;
            end else begin
               state_in = S_TRACE_RD;
            end
         end
         S_TRACE_RD:  state_in = S_TRACE_PAR;
         S_TRACE_PAR: state_in = status.par_ok ? S_TRACE_CHK : S_FAIL;
         S_TRACE_END: state_in = S_IDLE;
         S_FAIL:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      op        = OP_NONE;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = rsp_hold;
            if (accept) begin
               unique case (action_type'(req_action))
                  ACT_LOAD:   op = OP_LOAD;
                  ACT_SEARCH: op = OP_INIT;
                  ACT_STEP:   op = OP_STEP_RD;
                  ACT_NONE:   op = OP_NONE;
               endcase
            end
         end
         S_STEP_RSP:   op = OP_STEP_RSP;
         S_CLEAR:      op = OP_CLEAR;
         S_START:      op = OP_START;
         S_POP:        op = OP_SCAN_INIT;
         S_SCAN_RD:    op = OP_SCAN_RD;
         S_SCAN_CMP:   op = OP_SCAN_CMP;
         S_SHIFT_CHK:  op = OP_NONE;
         S_SHIFT_RD:   op = OP_SHIFT_RD;
         S_SHIFT_WR:   op = OP_SHIFT_WR;
         S_POP_DONE:   op = OP_POP_DONE;
         S_CLOSE:      op = OP_CLOSE;
         S_NB_ISSUE:   op = OP_NB_ISSUE;
         S_NB_EVAL:    op = OP_NB_EVAL;
         S_TRACE_INIT: op = OP_TRACE_INIT;
         S_TRACE_CHK:  op = OP_NONE;
         S_TRACE_RD:   op = OP_TRACE_RD;
         S_TRACE_PAR:  op = OP_TRACE_PAR;
         S_TRACE_END:  op = OP_TRACE_END;
         S_FAIL:       op = OP_FAIL;
         default:      op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/gasp_dp.sv
// Datapath of the path search unit: grid, cost, parent, open list and path memories.
module gasp_dp import gasp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  op_type              op,
   output dp_status_type       status,
   input  logic [ROW_W-1:0]    req_cell_row,
   input  logic [COL_W-1:0]    req_cell_col,
   input  logic [1:0]          req_cell_kind,
   input  logic [9:0]          req_step_index,
   input  logic [DIM_W-1:0]    cfg_rows,
   input  logic [DIM_W-1:0]    cfg_cols,
   input  logic                cfg_mode,
   input  logic [ROW_W-1:0]    cfg_start_row,
   input  logic [COL_W-1:0]    cfg_start_col,
   input  logic [ROW_W-1:0]    cfg_goal_row,
   input  logic [COL_W-1:0]    cfg_goal_col,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [CNT_W-1:0]    rsp_path_length,
   output logic [ROW_W-1:0]    rsp_step_row,
   output logic [COL_W-1:0]    rsp_step_col,
   output logic [DIR_W-1:0]    rsp_step_dir,
   output logic                rsp_last_step
);

   // Memories.
   logic [1:0]          cell_map_mem [CELLS];
   logic [COST_W:0]     cost_mem     [CELLS];
   logic [1:0]          parent_mem   [CELLS];
   logic [OPEN_W-1:0]   open_mem     [CELLS];
   logic [PATH_W-1:0]   path_mem     [CELLS];

   logic [1:0]        cm_rd_ff;
   logic [COST_W:0]   cost_rd_ff;
   logic [1:0]        par_rd_ff;
   logic [OPEN_W-1:0] open_rd_ff;
   logic [PATH_W-1:0] path_rd_ff;

   logic              cm_we, cost_we, par_we, open_we, path_we;
   logic [CELL_W-1:0] cm_wa, cost_wa, par_wa, open_wa, path_wa;
   logic [CELL_W-1:0] cm_ra, cost_ra, par_ra, open_ra, path_ra;
   logic [1:0]        cm_wd, par_wd;
   logic [COST_W:0]   cost_wd;
   logic [OPEN_W-1:0] open_wd;
   logic [PATH_W-1:0] path_wd;

   // Search registers.
   logic [DIM_W-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  found_ff, found_in;
   logic [CELL_W-1:0] clr_ff, clr_in;
   logic [CELL_W-1:0] scan_ff, scan_in;
   logic [CELL_W-1:0] best_idx_ff, best_idx_in;
   logic [F_W-1:0]    best_f_ff, best_f_in;
   logic [CELL_W-1:0] best_cell_ff, best_cell_in;
   logic [CELL_W-1:0] cur_ff, cur_in;
   logic [COST_W-1:0] cur_cost_ff, cur_cost_in;
   logic [1:0]        dir_ff, dir_in;
   logic [CNT_W-1:0]  tn_ff, tn_in;
   logic [DIR_W-1:0]  last_dir_ff, last_dir_in;
   logic [9:0]        idx_ff, idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [DIR_W-1:0]  rsp_dir_ff, rsp_dir_in;
   logic              rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic [DIM_W-1:0]  rows_c, cols_c;
   logic [CELL_W-1:0] start_cell;
   logic [ROW_W-1:0]  cur_r, nb_r, pr_r;
   logic [COL_W-1:0]  cur_c, nb_c, pr_c;
   logic              nb_in, par_ok;
   logic [H_W-1:0]    nb_h;
   logic [COST_W:0]   g_next;
   logic              improves, can_push, nb_blocked;
   logic [F_W-1:0]    open_f;
   logic [CELL_W-1:0] open_cell;

   assign rows_c     = clamp_dim(cfg_rows);
   assign cols_c     = clamp_dim(cfg_cols);
   assign start_cell = {cfg_start_row, cfg_start_col};
   assign cur_r      = cur_ff[CELL_W-1:COL_W];
   assign cur_c      = cur_ff[COL_W-1:0];
   assign open_f     = open_rd_ff[F_W-1:0];
   assign open_cell  = open_rd_ff[OPEN_W-1:F_W];

   // Neighbour of the current cell in the present direction.
   always_comb begin
      nb_r  = cur_r;
      nb_c  = cur_c;
      nb_in = 1'b0;
      unique case ({1'b0, dir_ff})
         DIR_UP: begin
            nb_r  = cur_r - 5'd1;
            nb_in = (cur_r != '0);
         end
         DIR_RIGHT: begin
            nb_c  = cur_c + 5'd1;
            nb_in = (({1'b0, cur_c} + 6'd1) < cols_ff);
         end
         DIR_DOWN: begin
            nb_r  = cur_r + 5'd1;
            nb_in = (({1'b0, cur_r} + 6'd1) < rows_ff);
         end
         default: begin
            nb_c  = cur_c - 5'd1;
            nb_in = (cur_c != '0);
         end
      endcase
   end

   // Parent of the current cell, found by undoing the stored move.
   always_comb begin
      pr_r   = cur_r;
      pr_c   = cur_c;
      par_ok = 1'b0;
      unique case ({1'b0, par_rd_ff})
         DIR_UP: begin
            pr_r   = cur_r + 5'd1;
            par_ok = (({1'b0, cur_r} + 6'd1) < rows_ff);
         end
         DIR_RIGHT: begin
            pr_c   = cur_c - 5'd1;
            par_ok = (cur_c != '0);
         end
         DIR_DOWN: begin
            pr_r   = cur_r - 5'd1;
            par_ok = (cur_r != '0);
         end
         default: begin
            pr_c   = cur_c + 5'd1;
            par_ok = (({1'b0, cur_c} + 6'd1) < cols_ff);
         end
      endcase
   end

   assign nb_h       = manhattan(nb_r, nb_c, cfg_goal_row, cfg_goal_col);
   assign g_next     = {1'b0, cur_cost_ff} + 12'd1;
   assign improves   = (g_next < {1'b0, COST_INF}) && (g_next[COST_W-1:0] < cost_rd_ff[COST_W-1:0]);
   assign can_push   = (count_ff < cap_ff);
   assign nb_blocked = cost_rd_ff[COST_W] || (cm_rd_ff == KIND_OBST);

   assign status.count_zero = (count_ff == '0);
   assign status.clear_done = (clr_ff == '1);
   assign status.start_oob  = ({1'b0, cfg_start_row} >= rows_ff) ||
                              ({1'b0, cfg_start_col} >= cols_ff);
   assign status.scan_last  = (({1'b0, scan_ff} + 11'd1) == count_ff);
   assign status.shift_more = (({1'b0, best_idx_ff} + 11'd1) < count_ff);
   assign status.is_goal    = (cm_rd_ff == KIND_GOAL);
   assign status.nb_in      = nb_in;
   assign status.dir_last   = (dir_ff == 2'd3);
   assign status.at_start   = (cur_ff == start_cell);
   assign status.trace_full = (({1'b0, tn_ff} + 12'd1) >= {1'b0, cap_ff});
   assign status.par_ok     = par_ok;

   // Memory port control.
   always_comb begin
      cm_we   = 1'b0;
      cm_wa   = {req_cell_row, req_cell_col};
      cm_wd   = (req_cell_kind == KIND_RSVD) ? KIND_OPEN : req_cell_kind;
      cm_ra   = (op == OP_POP_DONE) ? best_cell_ff : {nb_r, nb_c};
      cost_we = 1'b0;
      cost_wa = {nb_r, nb_c};
      cost_wd = {1'b0, g_next[COST_W-1:0]};
      cost_ra = (op == OP_POP_DONE) ? best_cell_ff : {nb_r, nb_c};
      par_we  = 1'b0;
      par_wa  = {nb_r, nb_c};
      par_wd  = dir_ff;
      par_ra  = cur_ff;
      open_we = 1'b0;
      open_wa = count_ff[CELL_W-1:0];
      open_wd = (cfg_mode) ? {nb_r, nb_c, F_W'(g_next[COST_W-1:0] + {5'd0, nb_h})}
                           : {nb_r, nb_c, F_W'(nb_h)};
      open_ra = (op == OP_SHIFT_RD) ? (best_idx_ff + 10'd1) : scan_ff;
      path_we = 1'b0;
      path_wa = tn_ff[CELL_W-1:0];
      path_wd = {cur_ff, last_dir_ff};
      path_ra = found_ff[CELL_W-1:0] - 10'd1 - req_step_index;
      unique case (op)
         OP_LOAD:  cm_we = 1'b1;
         OP_CLEAR: begin
            cost_we = 1'b1;
            cost_wa = clr_ff;
            cost_wd = {1'b0, COST_INF};
         end
         OP_START: begin
            cost_we = 1'b1;
            cost_wa = start_cell;
            cost_wd = '0;
            par_we  = 1'b1;
            par_wa  = start_cell;
            par_wd  = 2'd0;
            open_we = 1'b1;
            open_wa = '0;
            open_wd = {start_cell,
                       F_W'(manhattan(cfg_start_row, cfg_start_col,
                                      cfg_goal_row, cfg_goal_col))};
         end
         OP_SHIFT_WR: begin
            open_we = 1'b1;
            open_wa = best_idx_ff;
            open_wd = open_rd_ff;
         end
         OP_CLOSE: begin
            cost_we = 1'b1;
            cost_wa = cur_ff;
            cost_wd = {1'b1, cost_rd_ff[COST_W-1:0]};
         end
         OP_NB_EVAL: begin
            if (!nb_blocked) begin
               if (!cfg_mode) begin
                  par_we  = 1'b1;
                  open_we = can_push;
               end else if (improves) begin
                  cost_we = 1'b1;
                  par_we  = 1'b1;
                  open_we = can_push;
               end
            end
         end
         OP_TRACE_RD:  path_we = 1'b1;
         OP_TRACE_END: path_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cm_we) begin
         cell_map_mem[cm_wa] <= cm_wd;
      end
      cm_rd_ff <= cell_map_mem[cm_ra];
   end

   always_ff @(posedge clock) begin
      if (cost_we) begin
         cost_mem[cost_wa] <= cost_wd;
      end
      cost_rd_ff <= cost_mem[cost_ra];
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         parent_mem[par_wa] <= par_wd;
      end
      par_rd_ff <= parent_mem[par_ra];
   end

   always_ff @(posedge clock) begin
      if (open_we) begin
         open_mem[open_wa] <= open_wd;
      end
      open_rd_ff <= open_mem[open_ra];
   end

   always_ff @(posedge clock) begin
      if (path_we) begin
         path_mem[path_wa] <= path_wd;
      end
      path_rd_ff <= path_mem[path_ra];
   end

   // Register updates.
   always_comb begin
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      cap_in       = cap_ff;
      count_in     = count_ff;
      found_in     = found_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      best_idx_in  = best_idx_ff;
      best_f_in    = best_f_ff;
      best_cell_in = best_cell_ff;
      cur_in       = cur_ff;
      cur_cost_in  = cur_cost_ff;
      dir_in       = dir_ff;
      tn_in        = tn_ff;
      last_dir_in  = last_dir_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (op)
         OP_LOAD: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_LOADED;
            rsp_len_in    = '0;
            rsp_row_in    = '0;
            rsp_col_in    = '0;
            rsp_dir_in    = DIR_NONE;
            rsp_last_in   = 1'b0;
         end
         OP_STEP_RD: idx_in = req_step_index;
         OP_STEP_RSP: begin
            rsp_valid_in = 1'b1;
            rsp_len_in   = found_ff;
            if ({1'b0, idx_ff} >= found_ff) begin
               rsp_status_in = ST_BEYOND;
               rsp_row_in    = '0;
               rsp_col_in    = '0;
               rsp_dir_in    = DIR_NONE;
               rsp_last_in   = 1'b0;
            end else begin
               rsp_status_in = ST_FOUND;
               rsp_row_in    = path_rd_ff[PATH_W-1:PATH_W-ROW_W];
               rsp_col_in    = path_rd_ff[DIR_W+COL_W-1:DIR_W];
               rsp_last_in   = (({1'b0, idx_ff} + 11'd1) == found_ff);
               rsp_dir_in    = (({1'b0, idx_ff} + 11'd1) == found_ff) ? DIR_NONE
                                                                      : path_rd_ff[DIR_W-1:0];
            end
         end
         OP_INIT: begin
            rows_in  = rows_c;
            cols_in  = cols_c;
            cap_in   = {5'd0, rows_c} * {5'd0, cols_c};
            found_in = '0;
            count_in = '0;
            clr_in   = '0;
         end
         OP_CLEAR: clr_in = clr_ff + 10'd1;
         OP_START: count_in = 11'd1;
         OP_SCAN_INIT: scan_in = '0;
         OP_SCAN_CMP: begin
            if (scan_ff == '0 || open_f < best_f_ff) begin
               best_f_in    = open_f;
               best_idx_in  = scan_ff;
               best_cell_in = open_cell;
            end
            scan_in = scan_ff + 10'd1;
         end
         OP_SHIFT_WR: best_idx_in = best_idx_ff + 10'd1;
         OP_POP_DONE: begin
            count_in = count_ff - 11'd1;
            cur_in   = best_cell_ff;
            dir_in   = 2'd0;
         end
         OP_CLOSE: cur_cost_in = cost_rd_ff[COST_W-1:0];
         OP_NB_ISSUE: begin
            if (!nb_in) begin
               dir_in = dir_ff + 2'd1;
            end
         end
         OP_NB_EVAL: begin
            dir_in = dir_ff + 2'd1;
            if (!nb_blocked && (!cfg_mode || improves) && can_push) begin
               count_in = count_ff + 11'd1;
            end
         end
         OP_TRACE_INIT: begin
            tn_in       = '0;
            last_dir_in = DIR_NONE;
         end
         OP_TRACE_RD: tn_in = tn_ff + 11'd1;
         OP_TRACE_PAR: begin
            if (par_ok) begin
               cur_in      = {pr_r, pr_c};
               last_dir_in = {1'b0, par_rd_ff};
            end
         end
         OP_TRACE_END: begin
            found_in      = tn_ff + 11'd1;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FOUND;
            rsp_len_in    = tn_ff + 11'd1;
            rsp_row_in    = '0;
            rsp_col_in    = '0;
            rsp_dir_in    = DIR_NONE;
            rsp_last_in   = 1'b0;
         end
         OP_FAIL: begin
            found_in      = '0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_NOPATH;
            rsp_len_in    = '0;
            rsp_row_in    = '0;
            rsp_col_in    = '0;
            rsp_dir_in    = DIR_NONE;
            rsp_last_in   = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         found_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff       <= rows_in;
      cols_ff       <= cols_in;
      cap_ff        <= cap_in;
      clr_ff        <= clr_in;
      scan_ff       <= scan_in;
      best_idx_ff   <= best_idx_in;
      best_f_ff     <= best_f_in;
      best_cell_ff  <= best_cell_in;
      cur_ff        <= cur_in;
      cur_cost_ff   <= cur_cost_in;
      dir_ff        <= dir_in;
      tn_ff         <= tn_in;
      last_dir_ff   <= last_dir_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_path_length = rsp_len_ff;
   assign rsp_step_row    = rsp_row_ff;
   assign rsp_step_col    = rsp_col_ff;
   assign rsp_step_dir    = rsp_dir_ff;
   assign rsp_last_step   = rsp_last_ff;

endmodule
